// ===== src/mau_pkg.sv =====
package mau_pkg;

    localparam int W      = 32;          // residue width
    localparam int AW     = W + 1;       // signed operand width
    localparam int NUM_W  = W + 4;       // dividend and Bezout coefficient width
    localparam int CNT_W  = 6;
    localparam int DIV_STEPS = NUM_W;
    localparam int MUL_STEPS = W;

    localparam logic [2:0] OP_ADD   = 3'd0;
    localparam logic [2:0] OP_SUB   = 3'd1;
    localparam logic [2:0] OP_NEG   = 3'd2;
    localparam logic [2:0] OP_MUL   = 3'd3;
    localparam logic [2:0] OP_RECIP = 3'd4;
    localparam logic [2:0] OP_POW   = 3'd5;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_ZERO  = 2'd1;
    localparam logic [1:0] ST_NOINV = 2'd2;

    typedef enum logic [3:0] {
        CMD_NOP,
        CMD_CAPTURE,
        CMD_SET_RESULT,
        CMD_DIV_LOAD,
        CMD_DIV_STEP,
        CMD_DIV_STORE,
        CMD_MUL_LOAD,
        CMD_MUL_DBL,
        CMD_MUL_ADD,
        CMD_MUL_STORE,
        CMD_POW_INIT,
        CMD_EU_INIT,
        CMD_OUT
    } dp_cmd_t;

    typedef enum logic [2:0] {
        DS_A_FLOOR,
        DS_B_MOD,
        DS_A_NEGMAP,
        DS_EUCLID,
        DS_Y_FLOOR
    } div_sel_t;

    typedef enum logic [1:0] {
        MS_PQ,
        MS_RP,
        MS_PP
    } mul_sel_t;

    typedef enum logic [2:0] {
        RS_SIMPLE,
        RS_ONE,
        RS_ZERO_ERR,
        RS_NOINV,
        RS_R
    } res_sel_t;

    typedef struct packed {
        dp_cmd_t  cmd;
        div_sel_t dsel;
        mul_sel_t msel;
        res_sel_t rsel;
    } dp_ctrl_t;

    typedef struct packed {
        logic [2:0] op;
        logic       a_zero;
        logic       a_neg;
        logic       b_zero;
        logic       e_zero;
        logic       e_lsb;
        logic       eb_one;
        logic       eb_zero;
        logic       out_free;
    } dp_stat_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_DIV_RUN,
        S_DIV_DONE,
        S_LOAD_BMOD,
        S_POW_INIT,
        S_POW_CHECK,
        S_MUL_DBL,
        S_MUL_ADD,
        S_MUL_DONE,
        S_MUL_PP,
        S_EU_CHECK,
        S_FINISH
    } state_t;

endpackage

// ===== src/mau_dp.sv =====
module mau_dp
    import mau_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [W-1:0]     cfg_data,
    input  logic [2:0]       in_op,
    input  logic [AW-1:0]    in_a,
    input  logic [W-1:0]     in_b,
    input  dp_ctrl_t         ctrl,
    output dp_stat_t         stat,
    input  logic             out_ready,
    output logic             out_valid,
    output logic [W-1:0]     out_result,
    output logic [1:0]       out_status
);

    logic [W-1:0]        modulus_reg;
    logic [W-1:0]        m;
    logic [2:0]          op_reg;
    logic [AW-1:0]       a_reg;
    logic [W-1:0]        b_reg;
    logic [W-1:0]        p_reg, r_reg, e_reg;
    logic [W-1:0]        mx_reg, my_reg, macc_reg;
    logic [W-1:0]        ea_reg, eb_reg;
    logic signed [NUM_W-1:0] ex_reg, ey_reg, t_reg;
    logic [NUM_W-1:0]    num_reg;
    logic [W-1:0]        rem_reg, den_reg;
    logic                neg_reg;
    logic [W-1:0]        res_reg;
    logic [1:0]          stat_reg;
    logic                ov_reg;
    logic [W-1:0]        or_reg;
    logic [1:0]          os_reg;

    logic signed [W+2:0] sa, sm, sb, simple_s;
    logic [W-1:0]        simple_r;
    logic [W:0]          rem2;
    logic                ge;
    logic [W-1:0]        fix_floor;
    logic [W:0]          dbl, dbl_sub, addv, add_sub;
    logic [NUM_W-1:0]    a_mag, y_mag;

    assign m  = (modulus_reg == '0) ? W'(1) : modulus_reg;
    assign sa = $signed({{2{a_reg[AW-1]}}, a_reg});
    assign sm = $signed({3'b000, m});
    assign sb = $signed({3'b000, b_reg});

    always_comb begin
        simple_s = '0;
        case (op_reg)
            OP_ADD: begin
                simple_s = sa + sb;
                if (simple_s >= sm) simple_s = simple_s - sm;
            end
            OP_SUB: begin
                simple_s = sa - sb;
                if (simple_s < 0) simple_s = simple_s + sm;
            end
            OP_NEG: simple_s = (sa == 0) ? '0 : sm - sa;
            default: simple_s = '0;
        endcase
        simple_r = simple_s[W-1:0];
    end

    assign a_mag = a_reg[AW-1] ? NUM_W'(-$signed({{(NUM_W-AW){a_reg[AW-1]}}, a_reg}))
                               : NUM_W'(a_reg);
    assign y_mag = ey_reg[NUM_W-1] ? NUM_W'(-ey_reg) : NUM_W'(ey_reg);

    // One restoring division step: shift in the next dividend bit.
    assign rem2 = {rem_reg, num_reg[NUM_W-1]};
    assign ge   = rem2 >= {1'b0, den_reg};
    assign fix_floor = (neg_reg && rem_reg != '0) ? m - rem_reg : rem_reg;

    assign dbl     = {macc_reg, 1'b0};
    assign dbl_sub = dbl - {1'b0, m};
    assign addv    = {1'b0, macc_reg} + {1'b0, mx_reg};
    assign add_sub = addv - {1'b0, m};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg <= W'(1);
            ov_reg      <= 1'b0;
        end else begin
            if (cfg_we) modulus_reg <= cfg_data;
            if (ctrl.cmd == CMD_OUT) ov_reg <= 1'b1;
            else if (out_ready) ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        case (ctrl.cmd)
            CMD_CAPTURE: begin
                op_reg <= in_op;
                a_reg  <= in_a;
                b_reg  <= in_b;
            end
            CMD_SET_RESULT: begin
                case (ctrl.rsel)
                    RS_SIMPLE:   begin res_reg <= simple_r; stat_reg <= ST_OK;    end
                    RS_ONE:      begin res_reg <= W'(1);    stat_reg <= ST_OK;    end
                    RS_ZERO_ERR: begin res_reg <= '0;       stat_reg <= ST_ZERO;  end
                    RS_NOINV:    begin res_reg <= '0;       stat_reg <= ST_NOINV; end
                    RS_R:        begin res_reg <= r_reg;    stat_reg <= ST_OK;    end
                    default:     begin res_reg <= '0;       stat_reg <= ST_OK;    end
                endcase
            end
            CMD_DIV_LOAD: begin
                rem_reg <= '0;
                t_reg   <= '0;
                case (ctrl.dsel)
                    DS_B_MOD: begin
                        num_reg <= NUM_W'(b_reg); den_reg <= m; neg_reg <= 1'b0;
                    end
                    DS_EUCLID: begin
                        num_reg <= NUM_W'(ea_reg); den_reg <= eb_reg; neg_reg <= 1'b0;
                    end
                    DS_Y_FLOOR: begin
                        num_reg <= y_mag; den_reg <= m; neg_reg <= ey_reg[NUM_W-1];
                    end
                    default: begin
                        num_reg <= a_mag; den_reg <= m; neg_reg <= a_reg[AW-1];
                    end
                endcase
            end
            CMD_DIV_STEP: begin
                rem_reg <= ge ? W'(rem2 - {1'b0, den_reg}) : rem2[W-1:0];
                num_reg <= {num_reg[NUM_W-2:0], 1'b0};
                t_reg   <= (t_reg <<< 1) + (ge ? ey_reg : '0);
            end
            CMD_DIV_STORE: begin
                case (ctrl.dsel)
                    DS_A_FLOOR: p_reg <= fix_floor;
                    DS_B_MOD: begin
                        mx_reg <= p_reg; my_reg <= rem_reg; macc_reg <= '0;
                    end
                    DS_A_NEGMAP: begin
                        eb_reg <= m - rem_reg; ea_reg <= m;
                        ex_reg <= '0; ey_reg <= NUM_W'(1);
                    end
                    DS_EUCLID: begin
                        eb_reg <= rem_reg; ea_reg <= eb_reg;
                        ey_reg <= ex_reg - t_reg; ex_reg <= ey_reg;
                    end
                    DS_Y_FLOOR: begin
                        res_reg <= fix_floor; stat_reg <= ST_OK;
                    end
                    default: ;
                endcase
            end
            CMD_MUL_LOAD: begin
                macc_reg <= '0;
                my_reg   <= p_reg;
                mx_reg   <= (ctrl.msel == MS_RP) ? r_reg : p_reg;
            end
            CMD_MUL_DBL: begin
                macc_reg <= (dbl >= {1'b0, m}) ? dbl_sub[W-1:0] : dbl[W-1:0];
            end
            CMD_MUL_ADD: begin
                if (my_reg[W-1])
                    macc_reg <= (addv >= {1'b0, m}) ? add_sub[W-1:0] : addv[W-1:0];
                my_reg <= {my_reg[W-2:0], 1'b0};
            end
            CMD_MUL_STORE: begin
                case (ctrl.msel)
                    MS_PQ: begin res_reg <= macc_reg; stat_reg <= ST_OK; end
                    MS_RP: r_reg <= macc_reg;
                    MS_PP: begin p_reg <= macc_reg; e_reg <= e_reg >> 1; end
                    default: ;
                endcase
            end
            CMD_POW_INIT: begin
                r_reg <= (m == W'(1)) ? '0 : W'(1);
                e_reg <= b_reg;
            end
            CMD_EU_INIT: begin
                eb_reg <= a_reg[W-1:0]; ea_reg <= m;
                ex_reg <= '0; ey_reg <= NUM_W'(1);
            end
            CMD_OUT: begin
                or_reg <= res_reg;
                os_reg <= stat_reg;
            end
            default: ;
        endcase
    end

    always_comb begin
        stat.op       = op_reg;
        stat.a_zero   = a_reg == '0;
        stat.a_neg    = a_reg[AW-1];
        stat.b_zero   = b_reg == '0;
        stat.e_zero   = e_reg == '0;
        stat.e_lsb    = e_reg[0];
        stat.eb_one   = eb_reg == W'(1);
        stat.eb_zero  = eb_reg == '0;
        stat.out_free = !ov_reg || out_ready;
    end

    assign out_valid  = ov_reg;
    assign out_result = or_reg;
    assign out_status = os_reg;

endmodule

// ===== src/mau_ctrl.sv =====
module mau_ctrl
    import mau_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     in_valid,
    output logic     in_ready,
    input  dp_stat_t stat,
    output dp_ctrl_t ctrl
);

    state_t            state_reg, state_next;
    div_sel_t          dsel_reg, dsel_next;
    mul_sel_t          msel_reg, msel_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            dsel_reg  <= DS_A_FLOOR;
            msel_reg  <= MS_PQ;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            dsel_reg  <= dsel_next;
            msel_reg  <= msel_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: if (in_valid) state_next = S_DECODE;
            S_DECODE: begin
                case (stat.op)
                    OP_MUL: state_next = S_DIV_RUN;
                    OP_POW: state_next = stat.b_zero ? S_FINISH : S_DIV_RUN;
                    OP_RECIP: begin
                        if (stat.a_zero)     state_next = S_FINISH;
                        else if (stat.a_neg) state_next = S_DIV_RUN;
                        else                 state_next = S_EU_CHECK;
                    end
                    default: state_next = S_FINISH;
                endcase
            end
            S_DIV_RUN: if (cnt_reg == CNT_W'(DIV_STEPS - 1)) state_next = S_DIV_DONE;
            S_DIV_DONE: begin
                case (dsel_reg)
                    DS_A_FLOOR: state_next = (stat.op == OP_MUL) ? S_LOAD_BMOD : S_POW_INIT;
                    DS_B_MOD:   state_next = S_MUL_DBL;
                    DS_Y_FLOOR: state_next = S_FINISH;
                    default:    state_next = S_EU_CHECK;
                endcase
            end
            S_LOAD_BMOD: state_next = S_DIV_RUN;
            S_POW_INIT:  state_next = S_POW_CHECK;
            S_POW_CHECK: state_next = stat.e_zero ? S_FINISH : S_MUL_DBL;
            S_MUL_DBL:   state_next = S_MUL_ADD;
            S_MUL_ADD: begin
                if (cnt_reg == CNT_W'(MUL_STEPS - 1)) state_next = S_MUL_DONE;
                else                                   state_next = S_MUL_DBL;
            end
            S_MUL_DONE: begin
                case (msel_reg)
                    MS_PQ:   state_next = S_FINISH;
                    MS_RP:   state_next = S_MUL_PP;
                    default: state_next = S_POW_CHECK;
                endcase
            end
            S_MUL_PP:    state_next = S_MUL_DBL;
            S_EU_CHECK:  state_next = (stat.eb_zero && !stat.eb_one) ? S_FINISH : S_DIV_RUN;
            S_FINISH:    if (stat.out_free) state_next = S_IDLE;
            default:     state_next = S_IDLE;
        endcase
    end

    always_comb begin
        ctrl.cmd  = CMD_NOP;
        ctrl.dsel = dsel_reg;
        ctrl.msel = msel_reg;
        ctrl.rsel = RS_SIMPLE;
        dsel_next = dsel_reg;
        msel_next = msel_reg;
        cnt_next  = '0;
        in_ready  = 1'b0;
        case (state_reg)
            S_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) ctrl.cmd = CMD_CAPTURE;
            end
            S_DECODE: begin
                case (stat.op)
                    OP_MUL: begin
                        ctrl.cmd = CMD_DIV_LOAD; ctrl.dsel = DS_A_FLOOR;
                        dsel_next = DS_A_FLOOR;
                    end
                    OP_POW: begin
                        if (stat.b_zero) begin
                            ctrl.cmd = CMD_SET_RESULT; ctrl.rsel = RS_ONE;
                        end else begin
                            ctrl.cmd = CMD_DIV_LOAD; ctrl.dsel = DS_A_FLOOR;
                            dsel_next = DS_A_FLOOR;
                        end
                    end
                    OP_RECIP: begin
                        if (stat.a_zero) begin
                            ctrl.cmd = CMD_SET_RESULT; ctrl.rsel = RS_ZERO_ERR;
                        end else if (stat.a_neg) begin
                            ctrl.cmd = CMD_DIV_LOAD; ctrl.dsel = DS_A_NEGMAP;
                            dsel_next = DS_A_NEGMAP;
                        end else begin
                            ctrl.cmd = CMD_EU_INIT;
                        end
                    end
                    default: begin
                        ctrl.cmd = CMD_SET_RESULT; ctrl.rsel = RS_SIMPLE;
                    end
                endcase
            end
            S_DIV_RUN: begin
                ctrl.cmd = CMD_DIV_STEP;
                cnt_next = cnt_reg + CNT_W'(1);
            end
            S_DIV_DONE: begin
                ctrl.cmd = CMD_DIV_STORE;
                if (dsel_reg == DS_B_MOD) msel_next = MS_PQ;
            end
            S_LOAD_BMOD: begin
                ctrl.cmd = CMD_DIV_LOAD; ctrl.dsel = DS_B_MOD;
                dsel_next = DS_B_MOD;
            end
            S_POW_INIT: ctrl.cmd = CMD_POW_INIT;
            S_POW_CHECK: begin
                if (stat.e_zero) begin
                    ctrl.cmd = CMD_SET_RESULT; ctrl.rsel = RS_R;
                end else begin
                    ctrl.cmd  = CMD_MUL_LOAD;
                    ctrl.msel = stat.e_lsb ? MS_RP : MS_PP;
                    msel_next = stat.e_lsb ? MS_RP : MS_PP;
                end
            end
            S_MUL_DBL: begin
                ctrl.cmd = CMD_MUL_DBL;
                cnt_next = cnt_reg;
            end
            S_MUL_ADD: begin
                ctrl.cmd = CMD_MUL_ADD;
                cnt_next = cnt_reg + CNT_W'(1);
            end
            S_MUL_DONE: ctrl.cmd = CMD_MUL_STORE;
            S_MUL_PP: begin
                ctrl.cmd = CMD_MUL_LOAD; ctrl.msel = MS_PP;
                msel_next = MS_PP;
            end
            S_EU_CHECK: begin
                if (stat.eb_one) begin
                    ctrl.cmd = CMD_DIV_LOAD; ctrl.dsel = DS_Y_FLOOR;
                    dsel_next = DS_Y_FLOOR;
                end else if (stat.eb_zero) begin
                    ctrl.cmd = CMD_SET_RESULT; ctrl.rsel = RS_NOINV;
                end else begin
                    ctrl.cmd = CMD_DIV_LOAD; ctrl.dsel = DS_EUCLID;
                    dsel_next = DS_EUCLID;
                end
            end
            S_FINISH: if (stat.out_free) ctrl.cmd = CMD_OUT;
            default: ;
        endcase
    end

endmodule

// ===== src/modular_arithmetic_unit_top.sv =====
// Channel      Direction  Handshake               Payload
// s_ (input)   in         s_tvalid / s_tready     req_type, operand_a, operand_b
// m_ (result)  out        m_tvalid / m_tready     result, status
// cfg_         in         cfg_valid / cfg_ready   modulus
//
// One transaction at a time. Add, subtract, negate and the unused opcodes use neither
// the divider nor the multiplier. Every reduction runs the shared restoring divider
// and every modular multiply runs the shift-and-add unit, so multiply takes two
// reductions and one modular multiply, power a reduction plus one modular multiply
// per squaring or multiply, and reciprocal a divider pass per Euclid step plus a
// final reduction. Reset is synchronous and sets the modulus to 1. A result waits in
// the output register while the next input transaction is accepted and worked on.
module modular_arithmetic_unit_top
    import mau_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // req_type[2:0], operand_a[35:3], operand_b[67:36]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // result[31:0], status[33:32]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data
);

    dp_ctrl_t   ctrl;
    dp_stat_t   stat;
    logic [W-1:0] out_result;
    logic [1:0]   out_status;

    assign cfg_ready = 1'b1;

    mau_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .ctrl     (ctrl)
    );

    mau_dp u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_we     (cfg_valid),
        .cfg_data   (cfg_data),
        .in_op      (s_tdata[2:0]),
        .in_a       (s_tdata[35:3]),
        .in_b       (s_tdata[67:36]),
        .ctrl       (ctrl),
        .stat       (stat),
        .out_ready  (m_tready),
        .out_valid  (m_tvalid),
        .out_result (out_result),
        .out_status (out_status)
    );

    assign m_tdata = {6'b0, out_status, out_result};

endmodule
